// ----- rtl/pfb_pkg.sv -----
// Types, constants and codes shared by the phase fold binner.
`timescale 1ns / 1ps
package pfb_pkg;

   // Field widths
   localparam int PERIOD_W    = 32;
   localparam int TS_W        = 32;
   localparam int MAG_FIELD_W = 16;
   localparam int BIN_NUM_W   = 8;
   localparam int AVG_W       = 16;
   localparam int DENS_W      = 16;
   localparam int COUNT_W     = 24;
   localparam int SUM_W       = 40;

   // Step counter of the shared divider, wide enough for the longest pass
   localparam int STEP_W = 6;

   // Parameter defaults
   localparam int NUM_BINS_DEF    = 256;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd86400;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]    SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]    SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MOD,
      ST_MUL,
      ST_IDX,
      ST_RD,
      ST_UPD,
      ST_AVGL,
      ST_AVG,
      ST_DENL,
      ST_DEN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]                    operation;
      logic [TS_W-1:0]               timestamp;
      logic signed [MAG_FIELD_W-1:0] magnitude;
      logic [BIN_NUM_W-1:0]          bin_select;
   } req_type;

   typedef struct packed {
      logic [BIN_NUM_W-1:0]    bin_number;
      logic signed [AVG_W-1:0] average_magnitude;
      logic [DENS_W-1:0]       relative_density;
      logic [COUNT_W-1:0]      sample_count;
   } rsp_type;

endpackage

// ----- rtl/phase_fold_binner_unit.sv -----
// Phase fold binner: folds samples into phase bins held in one bin memory.
//
//   channel  direction  ports                             payload
//   req      in         req_valid, req_ready, req_data    req_type
//   rsp      out        rsp_valid, rsp_ready, rsp_data    rsp_type
//   csr      in         csr_wr_en, csr_wr_data            fold period
//
// One item at a time. A shared restoring divider retires one bit a cycle.
// Add: timestamp mod period, bin index division, read-modify-write, then the
// average and density divisions; Read: read, average and density. Clear and
// reset: a zeroing pass over the bin memory, one entry a cycle, with req_ready low.
// A result waits in the rsp register; the next item is accepted meanwhile and
// stalls only at its own end while rsp_ready is low.
`timescale 1ns / 1ps
module phase_fold_binner_unit
   import pfb_pkg::*;
#(
   parameter int NUM_BINS    = NUM_BINS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [PERIOD_W-1:0] csr_wr_data
);

   localparam int BIN_W   = $clog2(NUM_BINS);
   localparam int SEL_W   = (BIN_W > BIN_NUM_W) ? BIN_W : BIN_NUM_W;
   localparam int MAG_W   = (SAMPLE_BITS > MAG_FIELD_W) ? SAMPLE_BITS : MAG_FIELD_W;
   localparam int QW      = SUM_W;
   localparam int PROD_W  = PERIOD_W + BIN_W;
   localparam int ENTRY_W = SUM_W + COUNT_W;
   localparam int DPROD_W = COUNT_W + DENS_W;

   // Control registers
   state_type             state_ff, state_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic                  clear_ff, clear_in;
   logic [COUNT_W-1:0]    largest_ff, largest_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [1:0]            op_ff, op_in;
   logic [MAG_FIELD_W-1:0] mag_ff, mag_in;
   logic [PERIOD_W-1:0]   div_rem_ff, div_rem_in;
   logic [QW-1:0]         div_quo_ff, div_quo_in;
   logic [PERIOD_W-1:0]   div_dsr_ff, div_dsr_in;
   logic [STEP_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [AVG_W-1:0]      avg_ff, avg_in;
   logic [DENS_W-1:0]     den_ff, den_in;
   logic [BIN_NUM_W-1:0]  res_bin_ff, res_bin_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Bin memory: {sum, count} per bin
   logic [ENTRY_W-1:0]    bin_mem [NUM_BINS];
   logic [ENTRY_W-1:0]    mem_rd_ff;
   logic                  mem_we;
   logic [ENTRY_W-1:0]    mem_wdata;

   // Divider step
   logic [PERIOD_W:0]     div_wide;
   logic [PERIOD_W+1:0]   div_diff;
   logic                  div_ge;
   logic [PERIOD_W-1:0]   div_rem_step;
   logic [QW-1:0]         div_quo_step;
   logic                  div_last;

   // Helpers
   logic [PROD_W-1:0]     phase_prod;
   logic [BIN_W-1:0]      idx_raw;
   logic [SEL_W-1:0]      sel_wide;
   logic [SEL_W-1:0]      bin_wide;
   logic [SUM_W-1:0]      ent_sum;
   logic [COUNT_W-1:0]    ent_cnt;
   logic [COUNT_W-1:0]    cnt_new;
   logic [MAG_W-1:0]      mag_raw;
   logic signed [SAMPLE_BITS-1:0] samp_s;
   logic signed [SUM_W:0] samp_ext;
   logic signed [SUM_W:0] sum_old_ext;
   logic signed [SUM_W:0] sum_ext;
   logic [SUM_W-1:0]      sum_sat;
   logic [SUM_W-1:0]      sum_abs;
   logic [AVG_W-1:0]      quo_avg;
   logic [DPROD_W-1:0]    den_prod;

   assign div_wide     = {div_rem_ff, div_quo_ff[QW-1]};
   assign div_diff     = {1'b0, div_wide} - {2'b00, div_dsr_ff};
   assign div_ge       = !div_diff[PERIOD_W+1];
   assign div_rem_step = div_ge ? div_diff[PERIOD_W-1:0] : div_wide[PERIOD_W-1:0];
   assign div_quo_step = {div_quo_ff[QW-2:0], div_ge};
   assign div_last     = (div_cnt_ff == STEP_W'(1));

   assign phase_prod = PROD_W'(div_rem_ff) * PROD_W'(NUM_BINS);
   assign idx_raw    = div_quo_step[BIN_W-1:0];
   assign sel_wide   = SEL_W'(req_data.bin_select);
   assign bin_wide   = SEL_W'(bin_ff);

   assign ent_sum = mem_rd_ff[ENTRY_W-1:COUNT_W];
   assign ent_cnt = mem_rd_ff[COUNT_W-1:0];
   assign cnt_new = ent_cnt + COUNT_W'(1);

   assign mag_raw     = MAG_W'(mag_ff);
   assign samp_s      = mag_raw[SAMPLE_BITS-1:0];
   assign samp_ext    = (SUM_W+1)'(samp_s);
   assign sum_old_ext = (SUM_W+1)'($signed(ent_sum));
   assign sum_ext     = sum_old_ext + samp_ext;
   assign sum_sat     = (sum_ext[SUM_W] != sum_ext[SUM_W-1])
                        ? (sum_ext[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT)
                        : sum_ext[SUM_W-1:0];

   assign sum_abs  = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
   assign quo_avg  = div_quo_ff[AVG_W-1:0];
   assign den_prod = {cnt_ff, {DENS_W{1'b0}}} - DPROD_W'(cnt_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      bin_in       = bin_ff;
      clear_in     = clear_ff;
      largest_in   = largest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op_in        = op_ff;
      mag_in       = mag_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_dsr_in   = div_dsr_ff;
      div_cnt_in   = div_cnt_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      avg_in       = avg_ff;
      den_in       = den_ff;
      res_bin_in   = res_bin_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wdata    = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            if (bin_ff == BIN_W'(NUM_BINS - 1)) begin
               bin_in   = '0;
               clear_in = 1'b0;
               state_in = clear_ff ? ST_DONE : ST_IDLE;
            end else begin
               bin_in = bin_ff + BIN_W'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.operation;
               mag_in     = req_data.magnitude;
               res_bin_in = '0;
               avg_in     = '0;
               den_in     = '0;
               cnt_in     = '0;
               unique case (req_data.operation)
                  OP_ADD: begin
                     // a zero period folds everything into bin 0
                     div_dsr_in = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
                     div_rem_in = '0;
                     div_quo_in = QW'(req_data.timestamp) << (QW - TS_W);
                     div_cnt_in = STEP_W'(TS_W);
                     state_in   = ST_MOD;
                  end
                  OP_READ: begin
                     if (PERIOD_W'(req_data.bin_select) < PERIOD_W'(NUM_BINS)) begin
                        bin_in   = sel_wide[BIN_W-1:0];
                        state_in = ST_RD;
                     end else begin
                        res_bin_in = req_data.bin_select;
                        state_in   = ST_DONE;
                     end
                  end
                  OP_CLEAR: begin
                     bin_in     = '0;
                     largest_in = '0;
                     clear_in   = 1'b1;
                     state_in   = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_MOD: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff - STEP_W'(1);
            if (div_last) begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            // upper part of phase*bins is below the period, so only the
            // low bits remain to be divided
            div_rem_in = phase_prod[PROD_W-1:BIN_W];
            div_quo_in = QW'(phase_prod[BIN_W-1:0]) << (QW - BIN_W);
            div_cnt_in = STEP_W'(BIN_W);
            state_in   = ST_IDX;
         end

         ST_IDX: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff - STEP_W'(1);
            if (div_last) begin
               if (PERIOD_W'(idx_raw) >= PERIOD_W'(NUM_BINS)) begin
                  bin_in = BIN_W'(NUM_BINS - 1);
               end else begin
                  bin_in = idx_raw;
               end
               state_in = ST_RD;
            end
         end

         ST_RD: begin
            state_in = ST_UPD;
         end

         ST_UPD: begin
            res_bin_in = bin_wide[BIN_NUM_W-1:0];
            sum_in     = ent_sum;
            cnt_in     = ent_cnt;
            // a full bin takes no further samples
            if (op_ff == OP_ADD && ent_cnt != COUNT_MAX) begin
               sum_in    = sum_sat;
               cnt_in    = cnt_new;
               mem_we    = 1'b1;
               mem_wdata = {sum_sat, cnt_new};
               if (cnt_new > largest_ff) begin
                  largest_in = cnt_new;
               end
            end
            state_in = ST_AVGL;
         end

         ST_AVGL: begin
            if (cnt_ff == '0) begin
               state_in = ST_DENL;
            end else begin
               // |sum| <= count * 2^(SAMPLE_BITS-1): quotient fits SAMPLE_BITS
               div_rem_in = PERIOD_W'(sum_abs >> SAMPLE_BITS);
               div_quo_in = sum_abs << (QW - SAMPLE_BITS);
               div_dsr_in = PERIOD_W'(cnt_ff);
               div_cnt_in = STEP_W'(SAMPLE_BITS);
               state_in   = ST_AVG;
            end
         end

         ST_AVG: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff - STEP_W'(1);
            if (div_last) begin
               state_in = ST_DENL;
            end
         end

         ST_DENL: begin
            if (cnt_ff == '0) begin
               avg_in = '0;
            end else begin
               avg_in = sum_ff[SUM_W-1] ? (~quo_avg + AVG_W'(1)) : quo_avg;
            end
            if (largest_ff == '0) begin
               den_in   = '0;
               state_in = ST_DONE;
            end else begin
               // count <= largest, so the quotient fits DENS_W bits
               div_rem_in = PERIOD_W'(den_prod[DPROD_W-1:DENS_W]);
               div_quo_in = QW'(den_prod[DENS_W-1:0]) << (QW - DENS_W);
               div_dsr_in = PERIOD_W'(largest_ff);
               div_cnt_in = STEP_W'(DENS_W);
               state_in   = ST_DEN;
            end
         end

         ST_DEN: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff - STEP_W'(1);
            if (div_last) begin
               den_in   = div_quo_step[DENS_W-1:0];
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.bin_number        = res_bin_ff;
               rsp_data_in.average_magnitude = avg_ff;
               rsp_data_in.relative_density  = den_ff;
               rsp_data_in.sample_count      = cnt_ff;
               rsp_valid_in                  = 1'b1;
               state_in                      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         period_ff    <= PERIOD_RESET;
         bin_ff       <= '0;
         clear_ff     <= 1'b0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         bin_ff       <= bin_in;
         clear_ff     <= clear_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      mag_ff      <= mag_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_dsr_ff  <= div_dsr_in;
      div_cnt_ff  <= div_cnt_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      avg_ff      <= avg_in;
      den_ff      <= den_in;
      res_bin_ff  <= res_bin_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[bin_ff] <= mem_wdata;
      end
      mem_rd_ff <= bin_mem[bin_ff];
   end

endmodule
